/* hw/rtl/sap_pkg.sv */
// Shared types, constants and register codes of the smart-card ATR parser.
package sap_pkg;

	// Byte limit of one answer; later bytes only end the answer.
	localparam int MAX_ATR_BYTES = 33;
	localparam int BYTES_W       = 6;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FI    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_GUARD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WI    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_IFSC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BWI   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CWI   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CRC   = 3'd7;

	// Register values after reset.
	localparam logic [3:0] RST_FI    = 4'd1;
	localparam logic [3:0] RST_DI    = 4'd1;
	localparam logic [7:0] RST_GUARD = 8'd0;
	localparam logic [7:0] RST_WI    = 8'd10;
	localparam logic [7:0] RST_IFSC  = 8'd32;
	localparam logic [3:0] RST_BWI   = 4'd4;
	localparam logic [3:0] RST_CWI   = 4'd13;
	localparam logic       RST_CRC   = 1'b0;

	// Initial character values.
	localparam logic [7:0] TS_DIRECT  = 8'h3B;
	localparam logic [7:0] TS_INVERSE = 8'h3F;

	// Summary status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
	localparam logic [1:0] STATUS_BAD_TS    = 2'd3;

	// TCK check codes.
	localparam logic [1:0] TCK_ABSENT   = 2'd0;
	localparam logic [1:0] TCK_MATCH    = 2'd1;
	localparam logic [1:0] TCK_MISMATCH = 2'd2;

	// Protocol number of block transmission.
	localparam logic [3:0] PROTO_T1 = 4'd1;

	typedef struct packed {
		logic [3:0] fi;
		logic [3:0] di;
		logic [7:0] extra_guard;
		logic [7:0] wi;
		logic [7:0] ifsc;
		logic [3:0] bwi;
		logic [3:0] cwi;
		logic       crc;
	} sap_cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic       inverse_convention;
		logic [1:0] tck_state;
		logic [3:0] historical_count;
		logic [3:0] fi;
		logic [3:0] di;
		logic [7:0] extra_guard;
		logic [7:0] wi;
		logic [3:0] protocol;
		logic [7:0] ifsc;
		logic [7:0] bwi_cwi;
		logic       crc_checksum;
	} sap_result_t;

endpackage

/* hw/rtl/sap_in_if.sv */
// Byte channel that carries the answer-to-reset into the parser.
interface sap_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] atr_byte;
	logic       last;

	modport source (output valid, output atr_byte, output last, input ready);
	modport sink (input valid, input atr_byte, input last, output ready);
endinterface

/* hw/rtl/sap_out_if.sv */
// Summary channel that carries the parsed answer-to-reset parameters.
interface sap_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       inverse_convention;
	logic [1:0] tck_state;
	logic [3:0] historical_count;
	logic [3:0] fi;
	logic [3:0] di;
	logic [7:0] extra_guard;
	logic [7:0] wi;
	logic [3:0] protocol;
	logic [7:0] ifsc;
	logic [7:0] bwi_cwi;
	logic       crc_checksum;

	modport source (output valid, output status, output inverse_convention,
		output tck_state, output historical_count, output fi, output di,
		output extra_guard, output wi, output protocol, output ifsc,
		output bwi_cwi, output crc_checksum, input ready);
	modport sink (input valid, input status, input inverse_convention,
		input tck_state, input historical_count, input fi, input di,
		input extra_guard, input wi, input protocol, input ifsc,
		input bwi_cwi, input crc_checksum, output ready);
endinterface

/* hw/rtl/smartcard_atr_parser.sv */
// Top level: answer-to-reset parser with input register, parse core and result register.
// A summary is loaded into the result register when the last byte leaves the input register.
// Throughput: one byte per cycle, but a byte that ends the answer waits while the result register is full.
// A byte waits in the input register only while a finished summary is not yet taken.
// Reset (arst_n low, asynchronous) empties both registers, clears the parse state
// and loads the default-value registers with their documented values.
module smartcard_atr_parser import sap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata,
	sap_in_if.sink               in_ch,
	sap_out_if.source            out_ch
);

	sap_cfg_t    cfg;
	sap_result_t result;
	logic        emit;
	logic        free;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	sap_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// A held byte moves on unless it ends the answer and the result register is full.
	assign advance     = valid_s1 && (!last_s1 || free);
	assign in_ch.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.atr_byte;
			last_s1 <= in_ch.last;
		end
	end

	sap_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.atr_byte (byte_s1),
		.last     (last_s1),
		.cfg      (cfg),
		.emit     (emit),
		.result   (result)
	);

	sap_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.result (result),
		.free   (free),
		.out_ch (out_ch)
	);

endmodule

/* hw/rtl/sap_cfg_regs.sv */
// Default-value registers written through the configuration port.
module sap_cfg_regs import sap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata,
	output sap_cfg_t             cfg
);

	sap_cfg_t cfg_q;

	// Each write updates one register, truncated to its width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fi          <= RST_FI;
			cfg_q.di          <= RST_DI;
			cfg_q.extra_guard <= RST_GUARD;
			cfg_q.wi          <= RST_WI;
			cfg_q.ifsc        <= RST_IFSC;
			cfg_q.bwi         <= RST_BWI;
			cfg_q.cwi         <= RST_CWI;
			cfg_q.crc         <= RST_CRC;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEFAULT_FI:    cfg_q.fi          <= cfg_wdata[3:0];
				CFG_DEFAULT_DI:    cfg_q.di          <= cfg_wdata[3:0];
				CFG_DEFAULT_GUARD: cfg_q.extra_guard <= cfg_wdata;
				CFG_DEFAULT_WI:    cfg_q.wi          <= cfg_wdata;
				CFG_DEFAULT_IFSC:  cfg_q.ifsc        <= cfg_wdata;
				CFG_DEFAULT_BWI:   cfg_q.bwi         <= cfg_wdata[3:0];
				CFG_DEFAULT_CWI:   cfg_q.cwi         <= cfg_wdata[3:0];
				CFG_DEFAULT_CRC:   cfg_q.crc         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/sap_parse_core.sv */
// Byte-level parse state of the answer-to-reset and the summary it yields.
module sap_parse_core import sap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  atr_byte,
	input  logic        last,
	input  sap_cfg_t    cfg,
	output logic        emit,
	output sap_result_t result
);

	localparam logic [2:0] PH_TS    = 3'd0;
	localparam logic [2:0] PH_T0    = 3'd1;
	localparam logic [2:0] PH_IFACE = 3'd2;
	localparam logic [2:0] PH_HIST  = 3'd3;
	localparam logic [2:0] PH_TCK   = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	logic [2:0]         phase_q,     phase_n;
	logic [3:0]         pending_q,   pending_n;
	logic [3:0]         level_q,     level_n;
	logic [3:0]         hist_left_q, hist_left_n;
	logic [3:0]         hist_tot_q,  hist_tot_n;
	logic [BYTES_W-1:0] bytes_q,     bytes_n;
	logic [7:0]         ts_q,        ts_n;
	logic [7:0]         xor_q,       xor_n;
	logic [1:0]         tck_q,       tck_n;
	logic [7:0]         ta1_q,       ta1_n;
	logic               ta1_p_q,     ta1_p_n;
	logic [7:0]         tc1_q,       tc1_n;
	logic               tc1_p_q,     tc1_p_n;
	logic [7:0]         tc2_q,       tc2_n;
	logic               tc2_p_q,     tc2_p_n;
	logic [3:0]         td1_q,       td1_n;
	logic [3:0]         prev_td_q,   prev_td_n;
	logic               t1_found_q,  t1_found_n;
	logic [7:0]         t1_ifsc_q,   t1_ifsc_n;
	logic               t1_ifsc_p_q, t1_ifsc_p_n;
	logic [7:0]         t1_tb_q,     t1_tb_n;
	logic               t1_tb_p_q,   t1_tb_p_n;
	logic               t1_tc_q,     t1_tc_n;
	logic               t1_tc_p_q,   t1_tc_p_n;

	logic               take;
	logic               t1_level;
	logic [1:0]         status;

	assign take     = (bytes_q < BYTES_W'(MAX_ATR_BYTES));
	assign t1_level = !t1_found_q && (level_q >= 4'd3) && (prev_td_q == PROTO_T1);

	// Next parse state for the byte in hand.
	always_comb begin
		phase_n     = phase_q;
		pending_n   = pending_q;
		level_n     = level_q;
		hist_left_n = hist_left_q;
		hist_tot_n  = hist_tot_q;
		bytes_n     = bytes_q;
		ts_n        = ts_q;
		xor_n       = xor_q;
		tck_n       = tck_q;
		ta1_n       = ta1_q;
		ta1_p_n     = ta1_p_q;
		tc1_n       = tc1_q;
		tc1_p_n     = tc1_p_q;
		tc2_n       = tc2_q;
		tc2_p_n     = tc2_p_q;
		td1_n       = td1_q;
		prev_td_n   = prev_td_q;
		t1_found_n  = t1_found_q;
		t1_ifsc_n   = t1_ifsc_q;
		t1_ifsc_p_n = t1_ifsc_p_q;
		t1_tb_n     = t1_tb_q;
		t1_tb_p_n   = t1_tb_p_q;
		t1_tc_n     = t1_tc_q;
		t1_tc_p_n   = t1_tc_p_q;
		if (take) begin
			bytes_n = bytes_q + 1'b1;
			case (phase_q)
				PH_TS: begin
					ts_n    = atr_byte;
					phase_n = PH_T0;
				end
				PH_T0: begin
					xor_n       = xor_q ^ atr_byte;
					hist_tot_n  = atr_byte[3:0];
					hist_left_n = atr_byte[3:0];
					pending_n   = atr_byte[7:4];
					level_n     = 4'd1;
					phase_n     = PH_IFACE;
					if (atr_byte[7:4] == 4'd0) begin
						phase_n = (atr_byte[3:0] != 4'd0) ? PH_HIST : PH_TCK;
					end
				end
				PH_IFACE: begin
					xor_n = xor_q ^ atr_byte;
					// The lowest pending bit names the byte's role: TA, TB, TC or TD.
					if (pending_q[0]) begin
						pending_n[0] = 1'b0;
						if (level_q == 4'd1) begin
							ta1_n   = atr_byte;
							ta1_p_n = 1'b1;
						end
						if (t1_level) begin
							t1_ifsc_n   = atr_byte;
							t1_ifsc_p_n = 1'b1;
						end
					end else if (pending_q[1]) begin
						pending_n[1] = 1'b0;
						if (t1_level) begin
							t1_tb_n   = atr_byte;
							t1_tb_p_n = 1'b1;
						end
					end else if (pending_q[2]) begin
						pending_n[2] = 1'b0;
						if (level_q == 4'd1) begin
							tc1_n   = atr_byte;
							tc1_p_n = 1'b1;
						end
						if (level_q == 4'd2) begin
							tc2_n   = atr_byte;
							tc2_p_n = 1'b1;
						end
						if (t1_level) begin
							t1_tc_n   = atr_byte[0];
							t1_tc_p_n = 1'b1;
						end
					end else begin
						if (level_q == 4'd1) begin
							td1_n = atr_byte[3:0];
						end
						if (t1_level) begin
							t1_found_n = 1'b1;
						end
						prev_td_n = atr_byte[3:0];
						pending_n = atr_byte[7:4];
						if (level_q != 4'hF) begin
							level_n = level_q + 1'b1;
						end
					end
					// The level is complete once no interface byte is pending.
					if (pending_n == 4'd0) begin
						phase_n = (hist_left_q != 4'd0) ? PH_HIST : PH_TCK;
					end
				end
				PH_HIST: begin
					xor_n       = xor_q ^ atr_byte;
					hist_left_n = hist_left_q - 1'b1;
					if (hist_left_n == 4'd0) begin
						phase_n = PH_TCK;
					end
				end
				PH_TCK: begin
					tck_n   = (xor_q == atr_byte) ? TCK_MATCH : TCK_MISMATCH;
					phase_n = PH_DONE;
				end
				default: ;
			endcase
		end
	end

	// Summary status from the state after this byte.
	always_comb begin
		if (bytes_n < BYTES_W'(2)) begin
			status = STATUS_TOO_SHORT;
		end else if (phase_n == PH_IFACE) begin
			status = STATUS_TRUNCATED;
		end else if (ts_n != TS_DIRECT && ts_n != TS_INVERSE) begin
			status = STATUS_BAD_TS;
		end else if (phase_n == PH_HIST) begin
			status = STATUS_TRUNCATED;
		end else begin
			status = STATUS_OK;
		end
	end

	// Summary fields; a failed answer reports zeros beside its status.
	always_comb begin
		result        = '0;
		result.status = status;
		if (status == STATUS_OK) begin
			result.inverse_convention = (ts_n == TS_INVERSE);
			result.tck_state          = tck_n;
			result.historical_count   = hist_tot_n;
			result.fi          = ta1_p_n ? ta1_n[7:4] : cfg.fi;
			result.di          = ta1_p_n ? ta1_n[3:0] : cfg.di;
			result.extra_guard = tc1_p_n ? tc1_n : cfg.extra_guard;
			result.wi          = tc2_p_n ? tc2_n : cfg.wi;
			result.protocol    = td1_n;
			result.ifsc        = t1_ifsc_p_n ? t1_ifsc_n : cfg.ifsc;
			result.bwi_cwi     = t1_tb_p_n ? t1_tb_n : {cfg.bwi, cfg.cwi};
			result.crc_checksum = t1_tc_p_n ? t1_tc_n : cfg.crc;
		end
	end

	assign emit = step && last;

	// Parse state; the byte marked last returns it to the start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TS;
			pending_q   <= '0;
			level_q     <= '0;
			hist_left_q <= '0;
			hist_tot_q  <= '0;
			bytes_q     <= '0;
			ts_q        <= '0;
			xor_q       <= '0;
			tck_q       <= TCK_ABSENT;
			ta1_q       <= '0;
			ta1_p_q     <= 1'b0;
			tc1_q       <= '0;
			tc1_p_q     <= 1'b0;
			tc2_q       <= '0;
			tc2_p_q     <= 1'b0;
			td1_q       <= '0;
			prev_td_q   <= '0;
			t1_found_q  <= 1'b0;
			t1_ifsc_q   <= '0;
			t1_ifsc_p_q <= 1'b0;
			t1_tb_q     <= '0;
			t1_tb_p_q   <= 1'b0;
			t1_tc_q     <= 1'b0;
			t1_tc_p_q   <= 1'b0;
		end else if (step && last) begin
			phase_q     <= PH_TS;
			pending_q   <= '0;
			level_q     <= '0;
			hist_left_q <= '0;
			hist_tot_q  <= '0;
			bytes_q     <= '0;
			ts_q        <= '0;
			xor_q       <= '0;
			tck_q       <= TCK_ABSENT;
			ta1_q       <= '0;
			ta1_p_q     <= 1'b0;
			tc1_q       <= '0;
			tc1_p_q     <= 1'b0;
			tc2_q       <= '0;
			tc2_p_q     <= 1'b0;
			td1_q       <= '0;
			prev_td_q   <= '0;
			t1_found_q  <= 1'b0;
			t1_ifsc_q   <= '0;
			t1_ifsc_p_q <= 1'b0;
			t1_tb_q     <= '0;
			t1_tb_p_q   <= 1'b0;
			t1_tc_q     <= 1'b0;
			t1_tc_p_q   <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_n;
			pending_q   <= pending_n;
			level_q     <= level_n;
			hist_left_q <= hist_left_n;
			hist_tot_q  <= hist_tot_n;
			bytes_q     <= bytes_n;
			ts_q        <= ts_n;
			xor_q       <= xor_n;
			tck_q       <= tck_n;
			ta1_q       <= ta1_n;
			ta1_p_q     <= ta1_p_n;
			tc1_q       <= tc1_n;
			tc1_p_q     <= tc1_p_n;
			tc2_q       <= tc2_n;
			tc2_p_q     <= tc2_p_n;
			td1_q       <= td1_n;
			prev_td_q   <= prev_td_n;
			t1_found_q  <= t1_found_n;
			t1_ifsc_q   <= t1_ifsc_n;
			t1_ifsc_p_q <= t1_ifsc_p_n;
			t1_tb_q     <= t1_tb_n;
			t1_tb_p_q   <= t1_tb_p_n;
			t1_tc_q     <= t1_tc_n;
			t1_tc_p_q   <= t1_tc_p_n;
		end
	end

	// A summary leaves the parser ready for a fresh TS.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (phase_q == PH_TS && bytes_q == '0))
		else $error("parse state not cleared after summary");

	// The byte count never runs past the answer limit.
	a_bytes_cap: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= BYTES_W'(MAX_ATR_BYTES))
		else $error("byte count beyond answer limit");

	// Interface phase always has an interface byte outstanding.
	a_iface_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IFACE) |-> (pending_q != 4'd0))
		else $error("interface phase with nothing pending");

	// Historical phase always has a historical byte outstanding.
	a_hist_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HIST) |-> (hist_left_q != 4'd0))
		else $error("historical phase with no bytes left");

endmodule

/* hw/rtl/sap_out_reg.sv */
// Result register that holds one summary until its transfer completes.
module sap_out_reg import sap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  sap_result_t result,
	output logic        free,
	sap_out_if.source   out_ch
);

	logic        valid_q;
	sap_result_t data_q;

	// The register can take a new summary when empty or being drained.
	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out_ch.valid              = valid_q;
	assign out_ch.status             = data_q.status;
	assign out_ch.inverse_convention = data_q.inverse_convention;
	assign out_ch.tck_state          = data_q.tck_state;
	assign out_ch.historical_count   = data_q.historical_count;
	assign out_ch.fi                 = data_q.fi;
	assign out_ch.di                 = data_q.di;
	assign out_ch.extra_guard        = data_q.extra_guard;
	assign out_ch.wi                 = data_q.wi;
	assign out_ch.protocol           = data_q.protocol;
	assign out_ch.ifsc               = data_q.ifsc;
	assign out_ch.bwi_cwi            = data_q.bwi_cwi;
	assign out_ch.crc_checksum       = data_q.crc_checksum;

endmodule

/* test/tb_smartcard_atr_parser.sv */
// Self-checking testbench for the smart-card ATR parser: random answers checked against a predictor.
`timescale 1ns / 1ps

module tb_smartcard_atr_parser;
	import sap_pkg::*;

	// Interface byte roles within one level, in the order they arrive.
	localparam int ROLE_TA = 0;
	localparam int ROLE_TB = 1;
	localparam int ROLE_TC = 2;
	localparam int ROLE_TD = 3;

	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = 6;
	localparam int SETTINGS_RUN  = 5;
	localparam int PHASE_BYTES   = 145;

	typedef enum logic [2:0] {
		WAIT_TS, WAIT_T0, IFACE_BYTES, HIST_BYTES, WAIT_TCK, ANSWER_END
	} atr_phase_e;

	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} atr_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_wdata;

	sap_in_if  in_ch ();
	sap_out_if out_ch ();

	smartcard_atr_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #5 clk = ~clk;

	// Predictor copy of the default registers and of the parse state.
	sap_cfg_t   defaults;
	atr_phase_e phase_q;
	logic [3:0] want_mask, level_q, hist_left, hist_total, last_proto;
	logic [5:0] byte_count;
	logic [7:0] ts_q, xor_q;
	logic [1:0] tck_q;
	logic [8:0] ta1_q, tc1_q, tc2_q, t1_ta_q, t1_tb_q, t1_tc_q;
	logic [4:0] td1_q;
	logic       t1_done;

	// Scoreboard and traffic bookkeeping.
	atr_item_t   atr_stream[$];
	sap_result_t expected_summaries[$];
	int queued_bytes, accepted_bytes, phase_bytes;
	int error_count, answers_checked, idle_cycles, settings_written;
	int status_seen[4];

	function automatic void clear_answer();
		phase_q    = WAIT_TS;
		want_mask  = '0;
		level_q    = '0;
		hist_left  = '0;
		hist_total = '0;
		last_proto = '0;
		byte_count = '0;
		ts_q       = '0;
		xor_q      = '0;
		tck_q      = TCK_ABSENT;
		ta1_q      = '0;
		tc1_q      = '0;
		tc2_q      = '0;
		t1_ta_q    = '0;
		t1_tb_q    = '0;
		t1_tc_q    = '0;
		td1_q      = '0;
		t1_done    = 1'b0;
	endfunction

	// A level is finished once no interface byte is still announced.
	function automatic void close_level();
		if (want_mask == 4'h0)
			phase_q = (hist_left != 4'h0) ? HIST_BYTES : WAIT_TCK;
	endfunction

	function automatic void take_iface(input logic [7:0] b);
		int   role;
		logic t1_level;
		t1_level = !t1_done && level_q >= 4'd3 && last_proto == PROTO_T1;
		role = ROLE_TA;
		while (role < ROLE_TD && !want_mask[role])
			role++;
		want_mask[role] = 1'b0;
		xor_q ^= b;
		case (role)
			ROLE_TA: begin
				if (level_q == 4'd1) ta1_q = {1'b1, b};
				if (t1_level) t1_ta_q = {1'b1, b};
			end
			ROLE_TB: begin
				if (t1_level) t1_tb_q = {1'b1, b};
			end
			ROLE_TC: begin
				if (level_q == 4'd1) tc1_q = {1'b1, b};
				if (level_q == 4'd2) tc2_q = {1'b1, b};
				if (t1_level) t1_tc_q = {1'b1, b};
			end
			default: begin
				if (level_q == 4'd1) td1_q = {1'b1, b[3:0]};
				if (t1_level) t1_done = 1'b1;
				last_proto = b[3:0];
				want_mask  = b[7:4];
				if (level_q != 4'hF) level_q++;
			end
		endcase
		close_level();
	endfunction

	// Feeds one accepted byte to the predictor; returns 1 with the summary on a last byte.
	function automatic bit absorb_atr_byte(input logic [7:0] b, input logic last,
			output sap_result_t res);
		logic [1:0] st;
		res = '0;
		if (byte_count < MAX_ATR_BYTES) begin
			byte_count++;
			case (phase_q)
				WAIT_TS: begin
					ts_q    = b;
					phase_q = WAIT_T0;
				end
				WAIT_T0: begin
					xor_q      ^= b;
					hist_total = b[3:0];
					hist_left  = b[3:0];
					want_mask  = b[7:4];
					level_q    = 4'd1;
					phase_q    = IFACE_BYTES;
					close_level();
				end
				IFACE_BYTES: take_iface(b);
				HIST_BYTES: begin
					xor_q ^= b;
					hist_left--;
					if (hist_left == 4'h0) phase_q = WAIT_TCK;
				end
				WAIT_TCK: begin
					tck_q   = (xor_q == b) ? TCK_MATCH : TCK_MISMATCH;
					phase_q = ANSWER_END;
				end
				default: ;
			endcase
		end
		if (!last) return 1'b0;

		if (byte_count < 6'd2) st = STATUS_TOO_SHORT;
		else if (phase_q == IFACE_BYTES) st = STATUS_TRUNCATED;
		else if (ts_q != TS_DIRECT && ts_q != TS_INVERSE) st = STATUS_BAD_TS;
		else if (phase_q == HIST_BYTES) st = STATUS_TRUNCATED;
		else st = STATUS_OK;

		res.status = st;
		if (st == STATUS_OK) begin
			res.inverse_convention = (ts_q == TS_INVERSE);
			res.tck_state          = tck_q;
			res.historical_count   = hist_total;
			res.fi                 = ta1_q[8] ? ta1_q[7:4] : defaults.fi;
			res.di                 = ta1_q[8] ? ta1_q[3:0] : defaults.di;
			res.extra_guard        = tc1_q[8] ? tc1_q[7:0] : defaults.extra_guard;
			res.wi                 = tc2_q[8] ? tc2_q[7:0] : defaults.wi;
			res.protocol           = td1_q[3:0];
			res.ifsc               = t1_ta_q[8] ? t1_ta_q[7:0] : defaults.ifsc;
			res.bwi_cwi            = t1_tb_q[8] ? t1_tb_q[7:0] : {defaults.bwi, defaults.cwi};
			res.crc_checksum       = t1_tc_q[8] ? t1_tc_q[0] : defaults.crc;
		end
		clear_answer();
		return 1'b1;
	endfunction

	function automatic string show_summary(input sap_result_t r);
		return $sformatf("st=%0d inv=%0d tck=%0d k=%0d fi=%h di=%h n=%h wi=%h t=%h ifsc=%h bc=%h crc=%0d",
			r.status, r.inverse_convention, r.tck_state, r.historical_count, r.fi, r.di,
			r.extra_guard, r.wi, r.protocol, r.ifsc, r.bwi_cwi, r.crc_checksum);
	endfunction

	// XOR of T0 through the end of the sequence, which is what TCK must equal.
	function automatic logic [7:0] answer_xor(input logic [7:0] seq[$]);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 1; i < seq.size(); i++)
			acc ^= seq[i];
		return acc;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_protocol();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return PROTO_T1;
		if (r < 7) return 4'h0;
		return 4'($urandom);
	endfunction

	task automatic queue_answer(input logic [7:0] seq[$]);
		foreach (seq[i])
			atr_stream.insert(atr_stream.size(), atr_item_t'({seq[i], i == seq.size() - 1}));
		queued_bytes += seq.size();
		phase_bytes  += (seq.size() > MAX_ATR_BYTES) ? MAX_ATR_BYTES : seq.size();
	endtask

	// Builds an answer with random interface chain, history and TCK; TS may be invalid, TCK wrong or absent.
	task automatic build_answer(output logic [7:0] seq[$]);
		logic [7:0] b;
		logic [3:0] y;
		int depth, lvl, nhist, tck_mode;
		seq = {};
		if ($urandom_range(0, 9) == 0) seq.insert(seq.size(), 8'($urandom));
		else seq.insert(seq.size(), $urandom_range(0, 1) ? TS_INVERSE : TS_DIRECT);
		depth = $urandom_range(1, 6);
		nhist = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
		y = 4'($urandom);
		y[3] = (depth > 1) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
		seq.insert(seq.size(), {y, 4'(nhist)});
		lvl = 1;
		while (y != 4'h0) begin
			if (y[0]) seq.insert(seq.size(), pick_byte());
			if (y[1]) seq.insert(seq.size(), pick_byte());
			if (y[2]) seq.insert(seq.size(), pick_byte());
			if (y[3]) begin
				b[6:4] = 3'($urandom);
				b[7]   = (lvl < depth) ? ($urandom_range(0, 3) != 0) : 1'b0;
				b[3:0] = pick_protocol();
				seq.insert(seq.size(), b);
				y = b[7:4];
				lvl++;
			end else begin
				y = 4'h0;
			end
		end
		repeat (nhist) seq.insert(seq.size(), pick_byte());
		tck_mode = $urandom_range(0, 9);
		if (tck_mode < 6) seq.insert(seq.size(), answer_xor(seq));
		else if (tck_mode < 8)
			seq.insert(seq.size(), answer_xor(seq) ^ 8'($urandom_range(1, 255)));
		// Occasional bytes after the check byte, which the parser drops.
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) seq.insert(seq.size(), 8'($urandom));
	endtask

	// Mostly well-formed answers; the rest are cut short, pure noise or overlong.
	task automatic gen_answer();
		logic [7:0] seq[$];
		int r, n;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			build_answer(seq);
			if (r >= 78 && seq.size() > 1) begin
				n = $urandom_range(1, seq.size() - 1);
				while (seq.size() > n) void'(seq.pop_back());
			end
		end else if (r < 94) begin
			seq = {};
			n = $urandom_range(1, 40);
			if ($urandom_range(0, 1)) seq.insert(seq.size(), TS_DIRECT);
			while (seq.size() < n) seq.insert(seq.size(), 8'($urandom));
		end else begin
			build_answer(seq);
			n = $urandom_range(MAX_ATR_BYTES + 1, MAX_ATR_BYTES + 12);
			while (seq.size() < n) seq.insert(seq.size(), 8'($urandom));
		end
		queue_answer(seq);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_DEFAULT_FI:    defaults.fi          = data[3:0];
			CFG_DEFAULT_DI:    defaults.di          = data[3:0];
			CFG_DEFAULT_GUARD: defaults.extra_guard = data;
			CFG_DEFAULT_WI:    defaults.wi          = data;
			CFG_DEFAULT_IFSC:  defaults.ifsc        = data;
			CFG_DEFAULT_BWI:   defaults.bwi         = data[3:0];
			CFG_DEFAULT_CWI:   defaults.cwi         = data[3:0];
			CFG_DEFAULT_CRC:   defaults.crc         = data[0];
			default: ;
		endcase
	endtask

	task automatic program_defaults(input logic [63:0] raw);
		write_register(CFG_DEFAULT_FI, raw[7:0]);
		write_register(CFG_DEFAULT_DI, raw[15:8]);
		write_register(CFG_DEFAULT_GUARD, raw[23:16]);
		write_register(CFG_DEFAULT_WI, raw[31:24]);
		write_register(CFG_DEFAULT_IFSC, raw[39:32]);
		write_register(CFG_DEFAULT_BWI, raw[47:40]);
		write_register(CFG_DEFAULT_CWI, raw[55:48]);
		write_register(CFG_DEFAULT_CRC, raw[63:56]);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_written++;
	endtask

	// Waits until every byte has gone in and every summary has come out.
	task automatic wait_idle();
		while (accepted_bytes != queued_bytes || expected_summaries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Byte sender: bursts of transfers separated by random gaps.
	int        burst_left = 0;
	int        gap_left = 0;
	atr_item_t next_item;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid    <= 1'b0;
			in_ch.atr_byte <= '0;
			in_ch.last     <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left != 0 || atr_stream.size() == 0) begin
				if (gap_left != 0) gap_left--;
				in_ch.valid <= 1'b0;
			end else begin
				next_item = atr_stream.pop_front();
				in_ch.valid    <= 1'b1;
				in_ch.atr_byte <= next_item.data;
				in_ch.last     <= next_item.last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Summary receiver: ready follows a randomly chosen pattern that is picked anew when its run ends.
	rx_mode_e stall_mode = RX_ALWAYS;
	int       mode_left = 0;
	int       ready_tick = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = rx_mode_e'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			ready_tick++;
			case (stall_mode)
				RX_ALWAYS:   out_ch.ready <= 1'b1;
				RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: out_ch.ready <= (ready_tick % 7) >= 3;
				default:     out_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Prediction on each byte transfer, checking on each summary transfer, and the watchdog.
	sap_result_t predicted, got, want;
	string       diff;
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			accepted_bytes++;
			if (absorb_atr_byte(in_ch.atr_byte, in_ch.last, predicted))
				expected_summaries.insert(expected_summaries.size(), predicted);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.status             = out_ch.status;
			got.inverse_convention = out_ch.inverse_convention;
			got.tck_state          = out_ch.tck_state;
			got.historical_count   = out_ch.historical_count;
			got.fi                 = out_ch.fi;
			got.di                 = out_ch.di;
			got.extra_guard        = out_ch.extra_guard;
			got.wi                 = out_ch.wi;
			got.protocol           = out_ch.protocol;
			got.ifsc               = out_ch.ifsc;
			got.bwi_cwi            = out_ch.bwi_cwi;
			got.crc_checksum       = out_ch.crc_checksum;
			if (expected_summaries.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("[%0t] unexpected summary: %s", $realtime, show_summary(got));
			end else begin
				want = expected_summaries.pop_front();
				answers_checked++;
				status_seen[want.status]++;
				diff = "";
				if (got.status !== want.status) diff = {diff, " status"};
				if (got.inverse_convention !== want.inverse_convention)
					diff = {diff, " inverse_convention"};
				if (got.tck_state !== want.tck_state) diff = {diff, " tck_state"};
				if (got.historical_count !== want.historical_count)
					diff = {diff, " historical_count"};
				if (got.fi !== want.fi) diff = {diff, " fi"};
				if (got.di !== want.di) diff = {diff, " di"};
				if (got.extra_guard !== want.extra_guard) diff = {diff, " extra_guard"};
				if (got.wi !== want.wi) diff = {diff, " wi"};
				if (got.protocol !== want.protocol) diff = {diff, " protocol"};
				if (got.ifsc !== want.ifsc) diff = {diff, " ifsc"};
				if (got.bwi_cwi !== want.bwi_cwi) diff = {diff, " bwi_cwi"};
				if (got.crc_checksum !== want.crc_checksum) diff = {diff, " crc_checksum"};
				if (diff != "") begin
					error_count++;
					if (error_count <= 10) begin
						$display("[%0t] summary mismatch in%s", $realtime, diff);
						$display("  expected %s", show_summary(want));
						$display("  actual   %s", show_summary(got));
					end
				end
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d summaries outstanding",
				IDLE_LIMIT, expected_summaries.size());
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	// Test sequence: directed answers, then random answers under several register settings.
	initial begin
		logic [7:0] seq[$];
		logic [63:0] raw;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		defaults        = {RST_FI, RST_DI, RST_GUARD, RST_WI, RST_IFSC, RST_BWI, RST_CWI, RST_CRC};
		clear_answer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest valid answer, without TCK.
		seq = {TS_DIRECT, 8'h00};
		queue_answer(seq);
		// Inverse convention with a matching TCK.
		seq = {TS_INVERSE, 8'h00};
		seq.insert(seq.size(), answer_xor(seq));
		queue_answer(seq);
		// A single byte is too short.
		seq = {8'h5A};
		queue_answer(seq);
		// Unknown initial character.
		seq = {8'h12, 8'h00};
		queue_answer(seq);
		// TA1 announced but never sent.
		seq = {TS_DIRECT, 8'h10};
		queue_answer(seq);
		// One historical byte announced but missing.
		seq = {TS_DIRECT, 8'h01};
		queue_answer(seq);
		// TA1 and TD1 announcing T=1, then a wrong TCK.
		seq = {TS_DIRECT, 8'h90, 8'h96, 8'h01};
		seq.insert(seq.size(), answer_xor(seq) ^ 8'h5A);
		queue_answer(seq);
		// TC2 plus a full T=1 level three, one historical byte and a good TCK.
		seq = {TS_INVERSE, 8'h81, 8'hC1, 8'h00, 8'h71, 8'hFF, 8'h45, 8'h01, 8'h4B};
		seq.insert(seq.size(), answer_xor(seq));
		queue_answer(seq);
		wait_idle();

		for (int setting = 0; setting < SETTINGS_RUN; setting++) begin
			case (setting)
				0: raw = '0;
				1: raw = '1;
				default: raw = {$urandom, $urandom};
			endcase
			program_defaults(raw);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES)
				gen_answer();
			wait_idle();
		end

		$display("Checked %0d summaries (%0d ok, %0d too short, %0d truncated, %0d bad TS)",
			answers_checked, status_seen[STATUS_OK], status_seen[STATUS_TOO_SHORT],
			status_seen[STATUS_TRUNCATED], status_seen[STATUS_BAD_TS]);
		$display("from %0d bytes; default registers programmed %0d times, all-zero and all-one included",
			accepted_bytes, settings_written);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches in total", error_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sap_pkg.sv
hw/rtl/sap_in_if.sv
hw/rtl/sap_out_if.sv
hw/rtl/sap_cfg_regs.sv
hw/rtl/sap_parse_core.sv
hw/rtl/sap_out_reg.sv
hw/rtl/smartcard_atr_parser.sv
test/tb_smartcard_atr_parser.sv
